/* src/spe_pkg.sv */
// shared types, constants and codes of the shortest path engine
package spe_pkg;

  localparam int unsigned MaxNodesDef = 2048;
  localparam int unsigned MaxEdgesDef = 8192;
  localparam logic [23:0] Unreach     = 24'd10000000;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeAdd   = 2'd1;
  localparam logic [1:0] ModeRun   = 2'd2;
  localparam logic [1:0] ModeQuery = 2'd3;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_ADD1, S_ADD2, S_QRY, S_SWEEP, S_SEED, S_POP,
    S_POPRD, S_DN, S_DNRD, S_CHK, S_CHKRD, S_HEAD, S_EDGE1, S_EDGE, S_DRD,
    S_UP, S_UPRD, S_NEXT
  } spe_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_DISP, OP_ADD1, OP_ADD2, OP_QRY, OP_SWEEP, OP_SEED,
    OP_POP, OP_POPRD, OP_DN, OP_DNRD, OP_CHK, OP_CHKRD, OP_HEAD, OP_EDGE1,
    OP_EDGE, OP_DRD, OP_UP, OP_UPRD, OP_NEXT, OP_INIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } spe_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       disp_stop;
    logic       sweep_last;
    logic       run_oob;
    logic       heap_empty;
    logic       dn_done;
    logic       stale;
    logic       head_bad;
    logic       push;
    logic       up_root;
    logic       up_stop;
    logic       link_valid;
    logic       out_busy;
  } spe_sts_t;

  typedef struct packed {
    logic [10:0] src;
    logic [10:0] dst;
    logic [15:0] wt;
  } edge_ent_t;

  typedef struct packed {
    logic [23:0] cost;
    logic [10:0] node;
  } heap_ent_t;

endpackage

/* src/spe_if.sv */
// valid/ready channel interfaces for input and result words
interface spe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [10:0] node;
  logic [10:0] neighbor;
  logic [15:0] weight;
  modport source (output valid, output mode, output node, output neighbor,
                  output weight, input ready);
  modport sink (input valid, input mode, input node, input neighbor,
                input weight, output ready);
endinterface

interface spe_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [23:0] distance;
  modport source (output valid, output status, output distance, input ready);
  modport sink (input valid, input status, input distance, output ready);
endinterface

/* src/shortest_path_engine_top.sv */
// clear answers in dispatch, add edge passes ADD1 and ADD2, query passes QRY; each result word is registered
// run: a distance sweep over MAX_NODES entries, then per pop a heap sift-down and stale check,
//   then a walk of the node's edges with a sift-up per pushed edge; pop and push share one heap memory
// throughput: one word at a time; next word taken once its result is registered and not stalled
// reset: synchronous active low; after reset a sweep over MAX_NODES entries sets all
//   distances unreachable and all list heads defined before the first word is taken
module shortest_path_engine_top import spe_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned MAX_EDGES = MaxEdgesDef
) (
  input  logic      clk,
  input  logic      rst_n,
  spe_in_if.sink    in_ch,
  spe_out_if.source out_ch
);

  // command and status between controller and datapath
  spe_cmd_t cmd;
  spe_sts_t sts;

  // controller sequences each word: dispatch, edge add, query, and for a run the distance sweep, heap pop and edge walk
  spe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds edge lists, distances, the binary heap and the output register
  spe_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_ch.mode),
    .in_node      (in_ch.node),
    .in_neighbor  (in_ch.neighbor),
    .in_weight    (in_ch.weight),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_distance (out_ch.distance)
  );

endmodule

/* src/spe_ctrl.sv */
// controller state machine of the shortest path engine
module spe_ctrl import spe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  spe_sts_t sts,
  output spe_cmd_t cmd
);

  spe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:  if (sts.sweep_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid && in_ready) state_nxt = S_DISP;
      S_DISP: begin
        case (sts.mode)
          ModeClear: state_nxt = S_IDLE;
          ModeAdd:   state_nxt = sts.disp_stop ? S_IDLE : S_ADD1;
          ModeRun:   state_nxt = S_SWEEP;
          default:   state_nxt = sts.disp_stop ? S_IDLE : S_QRY;
        endcase
      end
      S_ADD1:  state_nxt = S_ADD2;
      S_ADD2:  state_nxt = S_IDLE;
      S_QRY:   state_nxt = S_IDLE;
      S_SWEEP: if (sts.sweep_last) state_nxt = S_SEED;
      S_SEED:  state_nxt = sts.run_oob ? S_IDLE : S_POP;
      S_POP:   state_nxt = sts.heap_empty ? S_IDLE : S_POPRD;
      S_POPRD: state_nxt = S_DN;
      S_DN:    state_nxt = S_DNRD;
      S_DNRD:  state_nxt = sts.dn_done ? S_CHK : S_DN;
      S_CHK:   state_nxt = S_CHKRD;
      S_CHKRD: state_nxt = sts.stale ? S_POP : S_HEAD;
      S_HEAD:  state_nxt = S_EDGE1;
      S_EDGE1: state_nxt = sts.head_bad ? S_POP : S_DRD;
      S_EDGE:  state_nxt = S_DRD;
      S_DRD:   state_nxt = sts.push ? S_UP : S_NEXT;
      S_UP:    state_nxt = sts.up_root ? S_NEXT : S_UPRD;
      S_UPRD:  state_nxt = sts.up_stop ? S_NEXT : S_UP;
      S_NEXT:  state_nxt = sts.link_valid ? S_EDGE : S_POP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state_r)
      S_INIT: cmd.op = OP_INIT;
      S_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) cmd.op = OP_LATCH;
      end
      S_DISP:  cmd.op = OP_DISP;
      S_ADD1:  cmd.op = OP_ADD1;
      S_ADD2:  cmd.op = OP_ADD2;
      S_QRY:   cmd.op = OP_QRY;
      S_SWEEP: cmd.op = OP_SWEEP;
      S_SEED:  cmd.op = OP_SEED;
      S_POP:   cmd.op = OP_POP;
      S_POPRD: cmd.op = OP_POPRD;
      S_DN:    cmd.op = OP_DN;
      S_DNRD:  cmd.op = OP_DNRD;
      S_CHK:   cmd.op = OP_CHK;
      S_CHKRD: cmd.op = OP_CHKRD;
      S_HEAD:  cmd.op = OP_HEAD;
      S_EDGE1: cmd.op = OP_EDGE1;
      S_EDGE:  cmd.op = OP_EDGE;
      S_DRD:   cmd.op = OP_DRD;
      S_UP:    cmd.op = OP_UP;
      S_UPRD:  cmd.op = OP_UPRD;
      S_NEXT:  cmd.op = OP_NEXT;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* src/spe_dp.sv */
// datapath of the shortest path engine: graph, distance and heap memories
module spe_dp import spe_pkg::*; #(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned MAX_EDGES = MaxEdgesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  spe_cmd_t    cmd,
  output spe_sts_t    sts,
  input  logic [1:0]  in_mode,
  input  logic [10:0] in_node,
  input  logic [10:0] in_neighbor,
  input  logic [15:0] in_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [23:0] out_distance
);

  localparam int unsigned HD = MAX_EDGES + 1;
  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned TW = $clog2(MAX_EDGES + 1);
  localparam int unsigned HW = $clog2(HD);
  localparam int unsigned FW = $clog2(HD + 1);

  // memories
  edge_ent_t       edge_mem [MAX_EDGES];
  logic [EW:0]     link_mem [MAX_EDGES];
  logic [EW-1:0]   lh_mem   [MAX_NODES];
  logic [23:0]     dist_mem [MAX_NODES];
  heap_ent_t       heap_mem [HD];

  edge_ent_t     edge_q;
  logic [EW:0]   link_q;
  logic [EW-1:0] lh_q;
  logic [23:0]   dist_q;
  heap_ent_t     ha_q, hb_q;

  logic [EW-1:0] e_ra, e_wa;
  logic          e_we;
  edge_ent_t     e_wd;
  logic [EW:0]   l_wd;
  logic [NW-1:0] lh_ra, lh_wa;
  logic          lh_we;
  logic [EW-1:0] lh_wd;
  logic [NW-1:0] d_ra, d_wa;
  logic          d_we;
  logic [23:0]   d_wd;
  logic [HW-1:0] ha_ra, hb_ra, h_wa;
  logic          h_we;
  heap_ent_t     h_wd;

  // registers
  logic [1:0]    mode_r;
  logic [10:0]   node_r, nb_r;
  logic [15:0]   wt_r;
  logic [TW-1:0] total_r, total_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  heap_ent_t     val_r, val_nxt;
  heap_ent_t     cur_r, cur_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [EW-1:0] k_r, k_nxt;
  logic [10:0]   to_r, to_nxt;
  logic [24:0]   sum_r, sum_nxt;
  logic [EW:0]   lnk_r, lnk_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic          os_r, os_nxt;
  logic [23:0]   od_r, od_nxt;

  logic          emit;
  logic          node_oob, nb_oob, full;
  logic [FW:0]   li, ri, pi;
  logic          l_ok, r_ok, l_sel, r_sel;
  heap_ent_t     child;
  logic          head_ok, relax, room;
  logic [24:0]   sum_c;

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_wa] <= e_wd;
      link_mem[e_wa] <= l_wd;
    end
    edge_q <= edge_mem[e_ra];
    link_q <= link_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (lh_we) lh_mem[lh_wa] <= lh_wd;
    lh_q <= lh_mem[lh_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) dist_mem[d_wa] <= d_wd;
    dist_q <= dist_mem[d_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    ha_q <= heap_mem[ha_ra];
    hb_q <= heap_mem[hb_ra];
  end

  assign node_oob = 32'(node_r) >= MAX_NODES;
  assign nb_oob   = 32'(nb_r) >= MAX_NODES;
  assign full     = 32'(total_r) >= MAX_EDGES;

  assign li    = {idx_r, 1'b1};
  assign ri    = li + 1'b1;
  assign pi    = ({1'b0, idx_r} - 1'b1) >> 1;
  assign l_ok  = li < (FW + 1)'(fill_r);
  assign r_ok  = ri < (FW + 1)'(fill_r);
  assign l_sel = l_ok && (ha_q.cost < val_r.cost);
  assign r_sel = r_ok && (hb_q.cost < (l_sel ? ha_q.cost : val_r.cost));
  assign child = r_sel ? hb_q : ha_q;

  assign head_ok = (TW'(e_r) < total_r) && (edge_q.src == cur_r.node);
  assign sum_c   = 25'(cur_r.cost) + 25'(edge_q.wt);
  assign relax   = (sum_r < 25'(Unreach)) && (sum_r < 25'(dist_q));
  assign room    = 32'(fill_r) < HD;

  always_comb begin
    sts            = '0;
    sts.mode       = mode_r;
    sts.disp_stop  = (mode_r == ModeAdd) ? (full || node_oob || nb_oob) : node_oob;
    sts.sweep_last = 32'(cnt_r) == MAX_NODES - 1;
    sts.run_oob    = node_oob;
    sts.heap_empty = fill_r == '0;
    sts.dn_done    = !(l_sel || r_sel);
    sts.stale      = cur_r.cost > dist_q;
    sts.head_bad   = !head_ok;
    sts.push       = relax && room;
    sts.up_root    = idx_r == '0;
    sts.up_stop    = ha_q.cost <= val_r.cost;
    sts.link_valid = lnk_r[EW];
    sts.out_busy   = ov_r && !out_ready;
  end

  always_comb begin
    e_ra = e_r;  e_wa = EW'(total_r);  e_we = 1'b0;
    e_wd = '{src: node_r, dst: nb_r, wt: wt_r};
    l_wd = {(TW'(k_r) < total_r) && (edge_q.src == node_r), k_r};
    lh_ra = NW'(node_r);  lh_wa = NW'(node_r);  lh_we = 1'b0;  lh_wd = EW'(total_r);
    d_ra = NW'(node_r);  d_wa = cnt_r;  d_we = 1'b0;  d_wd = Unreach;
    ha_ra = '0;  hb_ra = HW'(fill_r - 1'b1);  h_wa = HW'(idx_r);  h_we = 1'b0;
    h_wd = val_r;
    total_nxt = total_r;  fill_nxt = fill_r;  idx_nxt = idx_r;  val_nxt = val_r;
    cur_nxt = cur_r;  e_nxt = e_r;  k_nxt = k_r;  to_nxt = to_r;  sum_nxt = sum_r;
    lnk_nxt = lnk_r;  cnt_nxt = cnt_r;
    emit = 1'b0;  os_nxt = os_r;  od_nxt = od_r;
    case (cmd.op)
      // after reset: distances unreachable and list heads at a defined value
      OP_INIT: begin
        d_we = 1'b1;  cnt_nxt = cnt_r + 1'b1;
        lh_we = 1'b1;  lh_wa = cnt_r;  lh_wd = '0;
      end
      OP_DISP: begin
        cnt_nxt = '0;
        case (mode_r)
          ModeClear: begin
            total_nxt = '0;
            emit = 1'b1;  os_nxt = 1'b0;  od_nxt = '0;
          end
          ModeAdd: if (full || node_oob || nb_oob) begin
            emit = 1'b1;  os_nxt = full;  od_nxt = '0;
          end
          ModeQuery: if (node_oob) begin
            emit = 1'b1;  os_nxt = 1'b0;  od_nxt = Unreach;
          end
          default: ;
        endcase
      end
      OP_ADD1: begin
        e_ra = lh_q;  k_nxt = lh_q;
      end
      OP_ADD2: begin
        e_we = 1'b1;  lh_we = 1'b1;  total_nxt = total_r + 1'b1;
        emit = 1'b1;  os_nxt = 1'b0;  od_nxt = '0;
      end
      OP_QRY: begin
        emit = 1'b1;  os_nxt = 1'b0;  od_nxt = dist_q;
      end
      OP_SWEEP: begin
        d_we = 1'b1;  cnt_nxt = cnt_r + 1'b1;
      end
      OP_SEED: begin
        if (node_oob) begin
          emit = 1'b1;  os_nxt = 1'b0;  od_nxt = '0;
        end else begin
          d_we = 1'b1;  d_wa = NW'(node_r);  d_wd = '0;
          h_we = 1'b1;  h_wa = '0;  h_wd = '{cost: 24'd0, node: node_r};
          fill_nxt = FW'(1);
        end
      end
      OP_POP: if (fill_r == '0) begin
        emit = 1'b1;  os_nxt = 1'b0;  od_nxt = '0;
      end
      OP_POPRD: begin
        cur_nxt = ha_q;  val_nxt = hb_q;  fill_nxt = fill_r - 1'b1;  idx_nxt = '0;
      end
      OP_DN: begin
        ha_ra = HW'(li);  hb_ra = HW'(ri);
      end
      OP_DNRD: if (l_sel || r_sel) begin
        h_we = 1'b1;  h_wd = child;
        idx_nxt = r_sel ? FW'(ri) : FW'(li);
      end
      OP_CHK: begin
        h_we = 1'b1;  d_ra = NW'(cur_r.node);
      end
      OP_CHKRD: lh_ra = NW'(cur_r.node);
      OP_HEAD: begin
        e_ra = lh_q;  e_nxt = lh_q;
      end
      OP_EDGE1, OP_EDGE: begin
        to_nxt = edge_q.dst;  sum_nxt = sum_c;  lnk_nxt = link_q;
        d_ra = NW'(edge_q.dst);
      end
      OP_DRD: if (relax) begin
        d_we = 1'b1;  d_wa = NW'(to_r);  d_wd = sum_r[23:0];
        if (room) begin
          idx_nxt = fill_r;  fill_nxt = fill_r + 1'b1;
          val_nxt = '{cost: sum_r[23:0], node: to_r};
        end
      end
      OP_UP: begin
        ha_ra = HW'(pi);
        if (idx_r == '0) h_we = 1'b1;
      end
      OP_UPRD: begin
        h_we = 1'b1;
        if (ha_q.cost > val_r.cost) begin
          h_wd = ha_q;  idx_nxt = FW'(pi);
        end
      end
      OP_NEXT: begin
        e_ra = lnk_r[EW-1:0];  e_nxt = lnk_r[EW-1:0];
      end
      default: ;
    endcase
    ov_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      total_r <= total_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      mode_r <= in_mode;
      node_r <= in_node;
      nb_r   <= in_neighbor;
      wt_r   <= in_weight;
    end
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    cur_r <= cur_nxt;
    e_r   <= e_nxt;
    k_r   <= k_nxt;
    to_r  <= to_nxt;
    sum_r <= sum_nxt;
    lnk_r <= lnk_nxt;
    os_r  <= os_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid    = ov_r;
  assign out_status   = os_r;
  assign out_distance = od_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= HD) else $error("heap fill beyond depth");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= MAX_EDGES) else $error("edge count beyond store");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(ov_r && !out_ready)) else $error("result overwrites pending word");
  a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_ADD2 |=> total_r == $past(total_r) + 1'b1)
    else $error("edge count not advanced on add");

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the shortest path engine: directed and random words
`timescale 1ns / 1ps
module tb_top;
  import spe_pkg::*;

  localparam int unsigned NodeCnt    = MaxNodesDef;
  localparam int unsigned EdgeCap    = MaxEdgesDef;
  localparam int unsigned DenseEdges = 200;
  localparam int unsigned CycLimit   = 3000000;
  localparam int unsigned DrainWait  = 64;

  // receiver behavior: always ready, random stalls, or a fixed stall pattern
  localparam int RcvOpen    = 0;
  localparam int RcvRandom  = 1;
  localparam int RcvPattern = 2;

  typedef struct {
    logic        status;
    logic [23:0] distance;
  } result_t;

  logic clk;
  logic rst_n;

  spe_in_if  in_ch ();
  spe_out_if out_ch ();

  shortest_path_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // graph mirror and distance table kept in step with accepted words
  logic [10:0] graph_src [EdgeCap];
  logic [10:0] graph_dst [EdgeCap];
  logic [15:0] graph_wt  [EdgeCap];
  int          graph_edges;
  logic [23:0] dist_tbl  [NodeCnt];

  result_t     pending_q[$];
  int          mismatches;
  int          words_sent;
  int          results_seen;
  int          runs_sent;
  longint      cycle_cnt;

  // sender burst state and receiver stall control
  int          burst_left;
  int          max_gap;
  int          rcv_mode;
  int          hold_cycles;

  logic [10:0] node_pool [16];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
               pending_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: a long hold-off takes priority over the stall pattern
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (rcv_mode)
          RcvRandom:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RcvPattern: out_ch.ready <= ((cycle_cnt % 7) < 3);
          default:    out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    $display("mismatch on %s at result %0d: expected %0d, got %0d", what, results_seen,
             want, got);
  endtask

  // checker: every taken result word is compared against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("unexpected result word: status %0d distance %0d", out_ch.status,
                 out_ch.distance);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", longint'(want.status), longint'(out_ch.status));
        if (out_ch.distance !== want.distance)
          report_mismatch("distance", longint'(want.distance), longint'(out_ch.distance));
      end
      results_seen++;
    end
  end

  // shortest distances by repeated relaxation; order of edges does not matter
  task automatic solve_from(input logic [10:0] src);
    bit          changed;
    logic [24:0] sum;
    for (int n = 0; n < NodeCnt; n++) dist_tbl[n] = Unreach;
    dist_tbl[src] = '0;
    do begin
      changed = 1'b0;
      for (int e = 0; e < graph_edges; e++) begin
        sum = dist_tbl[graph_src[e]] + graph_wt[e];
        // sums at or past the unreachable value never relax anything
        if (sum < Unreach && sum < dist_tbl[graph_dst[e]]) begin
          dist_tbl[graph_dst[e]] = sum[23:0];
          changed = 1'b1;
        end
      end
    end while (changed);
  endtask

  // prediction of one accepted word
  task automatic predict_word(input logic [1:0] mode, input logic [10:0] node,
                              input logic [10:0] nb, input logic [15:0] wt);
    result_t res;
    res.status   = 1'b0;
    res.distance = '0;
    case (mode)
      ModeClear: graph_edges = 0;  // distances survive a clear
      ModeAdd: begin
        if (graph_edges >= EdgeCap) begin
          res.status = 1'b1;  // store full, edge dropped
        end else begin
          graph_src[graph_edges] = node;
          graph_dst[graph_edges] = nb;
          graph_wt[graph_edges]  = wt;
          graph_edges++;
        end
      end
      ModeRun: begin
        solve_from(node);
        runs_sent++;
      end
      default: res.distance = dist_tbl[node];
    endcase
    pending_q.insert(pending_q.size(), res);
  endtask

  // drive one word; gaps come between bursts, valid stays up inside a burst
  task automatic send_word(input logic [1:0] mode, input logic [10:0] node,
                           input logic [10:0] nb, input logic [15:0] wt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.node     <= node;
    in_ch.neighbor <= nb;
    in_ch.weight   <= wt;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(mode, node, nb, wt);
    words_sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // sender pause until every predicted result has come back
  task automatic wait_drained();
    go_idle();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_edge(input logic [10:0] s, input logic [10:0] d, input logic [15:0] w);
    send_word(ModeAdd, s, d, w);
  endtask

  task automatic query(input logic [10:0] n);
    send_word(ModeQuery, n, 11'($urandom()), 16'($urandom()));
  endtask

  // extremes of the fields, every mode, stale heap entries, clear keeping distances
  task automatic test_directed();
    rcv_mode = RcvOpen;
    max_gap  = 0;
    query(11'd0);
    query(11'd2047);
    add_edge(11'd0, 11'd2047, 16'hFFFF);
    add_edge(11'd2047, 11'd1, 16'h0000);
    // node 5 is first reached the long way, then improved through node 6
    add_edge(11'd0, 11'd5, 16'd100);
    add_edge(11'd0, 11'd6, 16'd1);
    add_edge(11'd6, 11'd5, 16'd1);
    add_edge(11'd5, 11'd5, 16'd0);
    add_edge(11'd1, 11'd0, 16'd3);
    send_word(ModeRun, 11'd0, 11'h7FF, 16'hFFFF);
    query(11'd0);
    query(11'd1);
    query(11'd5);
    query(11'd6);
    query(11'd2047);
    query(11'd7);
    send_word(ModeClear, 11'h7FF, 11'h7FF, 16'hFFFF);
    query(11'd5);
    send_word(ModeRun, 11'd0, 11'd0, 16'd0);
    query(11'd5);
    query(11'd0);
    send_word(ModeRun, 11'd2047, 11'd0, 16'd0);
    query(11'd2047);
    query(11'd0);
    wait_drained();
  endtask

  // a chain of maximum weights crosses the unreachable value partway along
  task automatic test_long_chain();
    rcv_mode = RcvRandom;
    max_gap  = 3;
    send_word(ModeClear, 11'd0, 11'd0, 16'd0);
    for (int i = 0; i < 160; i++)
      add_edge(11'(100 + i), 11'(101 + i), 16'hFFFF);
    send_word(ModeRun, 11'd100, 11'd0, 16'd0);
    for (int i = 150; i < 158; i++) query(11'(100 + i));
    query(11'd260);
    wait_drained();
  endtask

  // many parallel edges among few nodes, run on the dense graph, then clear
  task automatic test_dense_graph();
    rcv_mode = RcvOpen;
    max_gap  = 0;
    send_word(ModeClear, 11'd0, 11'd0, 16'd0);
    for (int i = 0; i < DenseEdges; i++)
      add_edge(11'($urandom_range(0, 47)), 11'($urandom_range(0, 47)),
               16'($urandom_range(1, 5000)));
    for (int i = 0; i < 3; i++)
      add_edge(11'($urandom()), 11'($urandom()), 16'($urandom()));
    send_word(ModeRun, 11'd3, 11'd0, 16'd0);
    for (int i = 0; i < 8; i++) query(11'($urandom_range(0, 63)));
    send_word(ModeClear, 11'd0, 11'd0, 16'd0);
    add_edge(11'd9, 11'd10, 16'd7);
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure();
    max_gap  = 0;
    rcv_mode = RcvOpen;
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) query(11'($urandom()));
    add_edge(11'd1, 11'd2, 16'd9);
    send_word(ModeRun, 11'd1, 11'd0, 16'd0);
    query(11'd2);
    wait_drained();
  endtask

  // random graphs: clear, load, run, query; with some noise words mixed in
  task automatic test_random_graphs();
    int          target;
    int          pool_n;
    int          k;
    logic [15:0] w;
    target = words_sent + 325;
    while (words_sent < target) begin
      rcv_mode = $urandom_range(0, 2);
      max_gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      pool_n   = $urandom_range(2, 16);
      for (int i = 0; i < pool_n; i++) node_pool[i] = 11'($urandom());
      if ($urandom_range(0, 4) != 0)
        send_word(ModeClear, 11'($urandom()), 11'($urandom()), 16'($urandom()));
      k = $urandom_range(1, 30);
      for (int i = 0; i < k; i++) begin
        case ($urandom_range(0, 3))
          0:       w = 16'($urandom());
          1:       w = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0000;
          default: w = 16'($urandom_range(0, 200));
        endcase
        add_edge(node_pool[$urandom_range(0, pool_n - 1)],
                 node_pool[$urandom_range(0, pool_n - 1)], w);
      end
      // broken sequences: a stray word now and then
      if ($urandom_range(0, 5) == 0)
        send_word(2'($urandom_range(0, 3)), 11'($urandom()), 11'($urandom()),
                  16'($urandom()));
      send_word(ModeRun, ($urandom_range(0, 7) == 0) ? 11'($urandom())
                : node_pool[$urandom_range(0, pool_n - 1)], 11'($urandom()),
                16'($urandom()));
      k = $urandom_range(2, 10);
      for (int i = 0; i < k; i++)
        query(($urandom_range(0, 5) == 0) ? 11'($urandom())
              : node_pool[$urandom_range(0, pool_n - 1)]);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.mode     = ModeClear;
    in_ch.node     = '0;
    in_ch.neighbor = '0;
    in_ch.weight   = '0;
    rst_n          = 1'b0;
    cycle_cnt      = 0;
    graph_edges    = 0;
    mismatches     = 0;
    words_sent     = 0;
    results_seen   = 0;
    runs_sent      = 0;
    burst_left     = 0;
    max_gap        = 0;
    rcv_mode       = RcvOpen;
    hold_cycles    = 0;
    for (int n = 0; n < NodeCnt; n++) dist_tbl[n] = Unreach;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_long_chain();
    test_backpressure();
    test_dense_graph();
    test_random_graphs();

    go_idle();
    repeat (DrainWait) @(posedge clk);
    $display("covered %0d words, %0d runs, %0d results checked, %0d mismatches",
             words_sent, runs_sent, results_seen, mismatches);
    $display("graphs included a max-weight chain, a dense edge set and long hold-offs");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
